[rtl/cgmvs_pkg.sv]
// ----------------------------------------------------------------------------
// cgmvs_pkg
// constants and types shared by the max-score vertex search block
// ----------------------------------------------------------------------------
package cgmvs_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int MAX_EDGES    = 65536;

  localparam int VTX_W    = 12;                       // vertex index
  localparam int VCNT_W   = 13;                       // vertex count, 0..MAX_VERTICES
  localparam int EADDR_W  = 16;                       // edge store address
  localparam int ECNT_W   = 17;                       // edge count, 0..MAX_EDGES
  localparam int WGT_W    = 32;
  localparam int SCORE_W  = 64;
  localparam int PROD_W   = 2 * SCORE_W;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;
  localparam int PADDR_W   = 2;

  localparam logic [PADDR_W-1:0] REG_SCORE_MODE = 2'd0;

  localparam logic signed [SCORE_W-1:0] THR_MODE0 = -64'sd65536;
  localparam logic signed [SCORE_W-1:0] THR_MODE1 = -64'sd4294967296;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 64'h8000_0000_0000_0000;

  typedef logic signed [SCORE_W-1:0] score_t;

endpackage

[rtl/csr_graph_max_vertex_score.sv]
// ----------------------------------------------------------------------------
// csr_graph_max_vertex_score
// loads a weighted graph in compressed row form and reports the first vertex
// with the highest score, using one shared serial multiplier and adder
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_*       in   tdata: neighbor, weight; tuser: has_edge, end_of_graph;
//                tlast: end_of_vertex
// m_*       out  tdata: vertex_index; tuser: found
// apb       in   score_mode at address 0
//
// loading takes one request per cycle
// after end_of_graph the block walks the stored rows; in mode 0 it sums the
// weights of each row's edges to even-numbered targets; mode 1 first sums
// each row and multiplies the sum by the row's degree on the serial
// multiplier, then sums each in-range edge's weight times its target's scaled
// row sum; s_tready stays low until the result sits in the output register
// reset clears counts and control; the graph memories need no clearing
// ----------------------------------------------------------------------------
module csr_graph_max_vertex_score (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cgmvs_pkg::S_TDATA_W-1:0]   s_tdata,   // neighbor[11:0], weight[43:12]
  input  logic [cgmvs_pkg::S_TUSER_W-1:0]   s_tuser,   // has_edge[0], end_of_graph[1]
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cgmvs_pkg::M_TDATA_W-1:0]   m_tdata,   // vertex_index[11:0]
  output logic                              m_tuser,   // found[0]
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cgmvs_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import cgmvs_pkg::*;

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_A_ROW  = 4'd1;
  localparam logic [3:0] ST_A_RWT  = 4'd2;
  localparam logic [3:0] ST_A_EDGE = 4'd3;
  localparam logic [3:0] ST_A_EACC = 4'd4;
  localparam logic [3:0] ST_A_STOR = 4'd5;
  localparam logic [3:0] ST_B_ROW  = 4'd6;
  localparam logic [3:0] ST_B_RWT  = 4'd7;
  localparam logic [3:0] ST_B_EDGE = 4'd8;
  localparam logic [3:0] ST_B_EGET = 4'd9;
  localparam logic [3:0] ST_B_SGET = 4'd10;
  localparam logic [3:0] ST_B_MACC = 4'd11;
  localparam logic [3:0] ST_B_CMP  = 4'd12;
  localparam logic [3:0] ST_MUL    = 4'd13;
  localparam logic [3:0] ST_EMIT   = 4'd14;

  function automatic score_t sat_add(score_t a, score_t b);
    logic [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    return s[SCORE_W-1:0];
  endfunction

  function automatic logic [SCORE_W-1:0] mag(score_t a);
    return a[SCORE_W-1] ? SCORE_W'(-a) : a;
  endfunction

  // memories
  logic [ECNT_W-1:0]  row_start_mem [0:MAX_VERTICES];
  logic [VTX_W-1:0]   edge_target_mem [0:MAX_EDGES-1];
  logic [WGT_W-1:0]   edge_weight_mem [0:MAX_EDGES-1];
  logic [SCORE_W-1:0] scaled_mem [0:MAX_VERTICES-1];

  logic [3:0]         state;
  logic [3:0]         mul_ret;
  logic               score_mode;
  logic               mode;
  logic [VCNT_W-1:0]  vertex_total;
  logic [ECNT_W-1:0]  edge_total;
  logic [VCNT_W-1:0]  vi;
  logic [ECNT_W-1:0]  ej;
  logic [ECNT_W-1:0]  row_begin;
  logic [ECNT_W-1:0]  row_end;
  score_t             acc;
  score_t             best_score;
  logic [VTX_W-1:0]   best_vertex;
  logic               updated;
  logic [PROD_W-1:0]  mcand;
  logic [SCORE_W-1:0] mplier;
  logic [PROD_W-1:0]  prod;
  logic               mneg;
  score_t             mul_res;
  logic [ECNT_W-1:0]  rs_q;
  logic [VTX_W-1:0]   et_q;
  logic [WGT_W-1:0]   ew_q;
  logic [SCORE_W-1:0] ss_q;
  logic               m_found;
  logic [VTX_W-1:0]   m_vertex;

  logic               accept;
  logic               edge_ok;
  logic               row_close;
  logic [ECNT_W-1:0]  edge_total_next;
  logic               rs_ren;
  logic               e_ren;
  logic               ss_ren;
  logic [VCNT_W-1:0]  rs_raddr;
  logic [PROD_W-1:0]  lim;
  score_t             mul_fin;
  score_t             w_ext;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_SCORE_MODE) ? {31'b0, score_mode} : 32'b0;
  assign s_tready = (state == ST_LOAD);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {{(M_TDATA_W-VTX_W){1'b0}}, m_vertex};
  assign m_tuser  = m_found;

  assign edge_ok = s_tuser[0] && (vertex_total < VCNT_W'(MAX_VERTICES))
                && (edge_total < ECNT_W'(MAX_EDGES));
  assign edge_total_next = edge_total + ECNT_W'(edge_ok);
  assign row_close = (s_tlast || s_tuser[1]) && (vertex_total < VCNT_W'(MAX_VERTICES));

  assign rs_ren   = ((state == ST_A_ROW) || (state == ST_B_ROW)) && (vi != vertex_total);
  assign rs_raddr = vi + VCNT_W'(1);
  assign e_ren    = ((state == ST_A_EDGE) || (state == ST_B_EDGE)) && (ej != row_end);
  assign ss_ren   = (state == ST_B_EGET) && mode && ({1'b0, et_q} < vertex_total);
  assign w_ext    = {{(SCORE_W-WGT_W){ew_q[WGT_W-1]}}, ew_q};

  // saturation of the finished serial product
  always_comb begin
    lim = {{(PROD_W-SCORE_W){1'b0}}, SCORE_MAX} + PROD_W'(mneg);
    if (prod > lim) begin
      mul_fin = mneg ? SCORE_MIN : SCORE_MAX;
    end else begin
      mul_fin = mneg ? SCORE_W'(-prod[SCORE_W-1:0]) : prod[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_close) begin
      row_start_mem[vertex_total + VCNT_W'(1)] <= edge_total_next;
    end
    if (rs_ren) begin
      rs_q <= row_start_mem[rs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && edge_ok) begin
      edge_target_mem[edge_total[EADDR_W-1:0]] <= s_tdata[VTX_W-1:0];
      edge_weight_mem[edge_total[EADDR_W-1:0]] <= s_tdata[VTX_W+WGT_W-1:VTX_W];
    end
    if (e_ren) begin
      et_q <= edge_target_mem[ej[EADDR_W-1:0]];
      ew_q <= edge_weight_mem[ej[EADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_A_STOR) begin
      scaled_mem[vi[VTX_W-1:0]] <= mul_res;
    end
    if (ss_ren) begin
      ss_q <= scaled_mem[et_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_SCORE_MODE) begin
      score_mode <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      vertex_total <= '0;
      edge_total   <= '0;
      m_tvalid     <= 1'b0;
      updated      <= 1'b0;
      best_vertex  <= '0;
      best_score   <= THR_MODE0;
      mode         <= 1'b0;
      mul_ret      <= ST_LOAD;
    end else begin
      if (state == ST_EMIT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            edge_total <= edge_total_next;
            if (row_close) begin
              vertex_total <= vertex_total + VCNT_W'(1);
            end
            if (s_tuser[1]) begin
              mode        <= score_mode;
              vi          <= '0;
              row_begin   <= '0;
              best_score  <= score_mode ? THR_MODE1 : THR_MODE0;
              best_vertex <= '0;
              updated     <= 1'b0;
              state       <= score_mode ? ST_A_ROW : ST_B_ROW;
            end
          end
        end
        ST_A_ROW: begin
          if (vi == vertex_total) begin
            vi        <= '0;
            row_begin <= '0;
            state     <= ST_B_ROW;
          end else begin
            state <= ST_A_RWT;
          end
        end
        ST_A_RWT: begin
          row_end <= rs_q;
          ej      <= row_begin;
          acc     <= '0;
          state   <= ST_A_EDGE;
        end
        ST_A_EDGE: begin
          if (ej == row_end) begin
            mcand   <= {{(PROD_W-SCORE_W){1'b0}}, mag(acc)};
            mplier  <= {{(SCORE_W-ECNT_W){1'b0}}, row_end - row_begin};
            mneg    <= acc[SCORE_W-1];
            prod    <= '0;
            mul_ret <= ST_A_STOR;
            state   <= ST_MUL;
          end else begin
            ej    <= ej + ECNT_W'(1);
            state <= ST_A_EACC;
          end
        end
        ST_A_EACC: begin
          acc   <= sat_add(acc, w_ext);
          state <= ST_A_EDGE;
        end
        ST_A_STOR: begin
          row_begin <= row_end;
          vi        <= vi + VCNT_W'(1);
          state     <= ST_A_ROW;
        end
        ST_B_ROW: begin
          state <= (vi == vertex_total) ? ST_EMIT : ST_B_RWT;
        end
        ST_B_RWT: begin
          row_end <= rs_q;
          ej      <= row_begin;
          acc     <= '0;
          state   <= ST_B_EDGE;
        end
        ST_B_EDGE: begin
          if (ej == row_end) begin
            state <= ST_B_CMP;
          end else begin
            ej    <= ej + ECNT_W'(1);
            state <= ST_B_EGET;
          end
        end
        ST_B_EGET: begin
          if (!mode) begin
            if (!et_q[0]) begin
              acc <= sat_add(acc, w_ext);
            end
            state <= ST_B_EDGE;
          end else begin
            state <= ss_ren ? ST_B_SGET : ST_B_EDGE;
          end
        end
        ST_B_SGET: begin
          mcand   <= {{(PROD_W-SCORE_W){1'b0}}, mag(w_ext)};
          mplier  <= mag(ss_q);
          mneg    <= w_ext[SCORE_W-1] ^ ss_q[SCORE_W-1];
          prod    <= '0;
          mul_ret <= ST_B_MACC;
          state   <= ST_MUL;
        end
        ST_B_MACC: begin
          acc   <= sat_add(acc, mul_res);
          state <= ST_B_EDGE;
        end
        ST_B_CMP: begin
          if (acc > best_score) begin
            best_score  <= acc;
            best_vertex <= vi[VTX_W-1:0];
            updated     <= 1'b1;
          end
          row_begin <= row_end;
          vi        <= vi + VCNT_W'(1);
          state     <= ST_B_ROW;
        end
        ST_MUL: begin
          if (mplier == '0) begin
            mul_res <= mul_fin;
            state   <= mul_ret;
          end else begin
            if (mplier[0]) begin
              prod <= prod + mcand;
            end
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_found      <= updated;
            m_vertex     <= updated ? best_vertex : '0;
            vertex_total <= '0;
            edge_total   <= '0;
            state        <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    vertex_total <= VCNT_W'(MAX_VERTICES) && edge_total <= ECNT_W'(MAX_EDGES))
    else $error("graph counters beyond store size");

  a_busy_after_graph: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[1]) |=> !s_tready)
    else $error("request taken while scoring");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("vertex index nonzero without a find");
`endif

endmodule
